// ----- rtl/rvd_pkg.sv -----
// Shared definitions for the RV32I instruction decoder.
// Holds opcodes, funct fields, mnemonic codes and the funct3 lookup tables.
// No dependencies.
package rvd_pkg;

  typedef logic [5:0] mnem_t;
  typedef logic [6:0] opcode_t;
  typedef logic [2:0] funct3_t;
  typedef logic [6:0] funct7_t;

  localparam int unsigned XLEN = 32;

  localparam opcode_t OP_LUI    = 7'h37;
  localparam opcode_t OP_AUIPC  = 7'h17;
  localparam opcode_t OP_JAL    = 7'h6f;
  localparam opcode_t OP_JALR   = 7'h67;
  localparam opcode_t OP_BRANCH = 7'h63;
  localparam opcode_t OP_LOAD   = 7'h03;
  localparam opcode_t OP_STORE  = 7'h23;
  localparam opcode_t OP_ALUI   = 7'h13;
  localparam opcode_t OP_ALUR   = 7'h33;
  localparam opcode_t OP_SYSTEM = 7'h73;

  localparam logic [XLEN-1:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [XLEN-1:0] WORD_EBREAK = 32'h0010_0073;

  localparam funct3_t F3_ADD_SUB = 3'd0;
  localparam funct3_t F3_SLL     = 3'd1;
  localparam funct3_t F3_SRL_SRA = 3'd5;

  localparam funct7_t F7_BASE = 7'h00;
  localparam funct7_t F7_ALT  = 7'h20;

  localparam mnem_t MN_ILLEGAL = 6'd0;
  localparam mnem_t MN_ECALL   = 6'd1;
  localparam mnem_t MN_EBREAK  = 6'd2;
  localparam mnem_t MN_LUI     = 6'd3;
  localparam mnem_t MN_AUIPC   = 6'd4;
  localparam mnem_t MN_JAL     = 6'd5;
  localparam mnem_t MN_JALR    = 6'd6;
  localparam mnem_t MN_BEQ     = 6'd7;
  localparam mnem_t MN_BNE     = 6'd8;
  localparam mnem_t MN_BLT     = 6'd9;
  localparam mnem_t MN_BGE     = 6'd10;
  localparam mnem_t MN_BLTU    = 6'd11;
  localparam mnem_t MN_BGEU    = 6'd12;
  localparam mnem_t MN_LB      = 6'd13;
  localparam mnem_t MN_LH      = 6'd14;
  localparam mnem_t MN_LW      = 6'd15;
  localparam mnem_t MN_LBU     = 6'd16;
  localparam mnem_t MN_LHU     = 6'd17;
  localparam mnem_t MN_SB      = 6'd18;
  localparam mnem_t MN_SH      = 6'd19;
  localparam mnem_t MN_SW      = 6'd20;
  localparam mnem_t MN_ADDI    = 6'd21;
  localparam mnem_t MN_SLTI    = 6'd22;
  localparam mnem_t MN_SLTIU   = 6'd23;
  localparam mnem_t MN_XORI    = 6'd24;
  localparam mnem_t MN_ORI     = 6'd25;
  localparam mnem_t MN_ANDI    = 6'd26;
  localparam mnem_t MN_SLLI    = 6'd27;
  localparam mnem_t MN_SRLI    = 6'd28;
  localparam mnem_t MN_SRAI    = 6'd29;
  localparam mnem_t MN_ADD     = 6'd30;
  localparam mnem_t MN_SUB     = 6'd31;
  localparam mnem_t MN_SLL     = 6'd32;
  localparam mnem_t MN_SLT     = 6'd33;
  localparam mnem_t MN_SLTU    = 6'd34;
  localparam mnem_t MN_XOR     = 6'd35;
  localparam mnem_t MN_SRL     = 6'd36;
  localparam mnem_t MN_SRA     = 6'd37;
  localparam mnem_t MN_OR      = 6'd38;
  localparam mnem_t MN_AND     = 6'd39;
  localparam mnem_t MN_CSRRW   = 6'd40;
  localparam mnem_t MN_CSRRS   = 6'd41;
  localparam mnem_t MN_CSRRC   = 6'd42;
  localparam mnem_t MN_CSRRWI  = 6'd43;
  localparam mnem_t MN_CSRRSI  = 6'd44;
  localparam mnem_t MN_CSRRCI  = 6'd45;

  // funct3 lookup, index 0 first
  localparam mnem_t BR_CODE [8] = '{MN_BEQ, MN_BNE, MN_ILLEGAL, MN_ILLEGAL,
                                    MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};
  localparam mnem_t LD_CODE [8] = '{MN_LB, MN_LH, MN_LW, MN_ILLEGAL,
                                    MN_LBU, MN_LHU, MN_ILLEGAL, MN_ILLEGAL};
  localparam mnem_t ST_CODE [8] = '{MN_SB, MN_SH, MN_SW, MN_ILLEGAL,
                                    MN_ILLEGAL, MN_ILLEGAL, MN_ILLEGAL, MN_ILLEGAL};
  localparam mnem_t AI_CODE [8] = '{MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU,
                                    MN_XORI, MN_ILLEGAL, MN_ORI, MN_ANDI};
  localparam mnem_t AR_CODE [8] = '{MN_ADD, MN_SLL, MN_SLT, MN_SLTU,
                                    MN_XOR, MN_SRL, MN_OR, MN_AND};
  localparam mnem_t CS_CODE [8] = '{MN_ILLEGAL, MN_CSRRW, MN_CSRRS, MN_CSRRC,
                                    MN_ILLEGAL, MN_CSRRWI, MN_CSRRSI, MN_CSRRCI};

endpackage

// ----- rtl/rv32i_instruction_decoder.sv -----
// RV32I instruction decoder, top level.
// Register stage, decode logic and result register; uses rvd_pkg.
//
// Usage:
//   Input channel: drive in_instruction_word and in_instruction_address with
//   start high; the request is taken at a rising edge where start is high and
//   busy is low. busy is high only while rst_n is low, so one request can be
//   taken in every cycle.
//   Result channel: out_valid is high for exactly one cycle per request, with
//   the mnemonic code, illegal flag, register fields, immediate, branch or jump
//   target and CSR number on the out_ ports for that cycle.
//   Path: the input register holds the accepted request, then the decode
//   logic feeds the result register that drives the out_ ports.
//   Throughput: one request per cycle; between the two registers the work is an
//   opcode, funct3 and funct7 decode with table lookups and one 32-bit address add.
//   Reset: synchronous, active low; clears both valid flags, so no result is
//   shown for requests in flight. The receiver cannot stall: results appear
//   in the order taken and are never held.
module rv32i_instruction_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    in_instruction_word,
  input  logic [31:0]                    in_instruction_address,
  output logic                           out_valid,
  output logic [5:0]                     out_mnemonic_code,
  output logic                           out_illegal_flag,
  output logic [4:0]                     out_dest_reg,
  output logic [4:0]                     out_src1_reg,
  output logic [4:0]                     out_src2_reg,
  output logic signed [31:0]             out_immediate_value,
  output logic [31:0]                    out_target_address,
  output logic [11:0]                    out_csr_number
);

  logic              in_vld_r;
  logic [31:0]       word_r;
  logic [31:0]       addr_r;

  logic              res_vld_r;
  rvd_pkg::mnem_t    code_r;
  logic              illegal_r;
  logic [4:0]        rd_r;
  logic [4:0]        rs1_r;
  logic [4:0]        rs2_r;
  logic [31:0]       imm_r;
  logic [31:0]       tgt_r;
  logic [11:0]       csr_r;

  rvd_pkg::mnem_t    code_nxt;
  logic [4:0]        rd_nxt;
  logic [4:0]        rs1_nxt;
  logic [4:0]        rs2_nxt;
  logic [31:0]       imm_nxt;
  logic [31:0]       tgt_nxt;
  logic [11:0]       csr_nxt;

  logic              use_rd;
  logic              use_rs1;
  logic              use_rs2;
  logic              use_tgt;
  logic              use_csr;
  rvd_pkg::funct3_t  f3;
  rvd_pkg::funct7_t  f7;
  logic [31:0]       imm_i;
  logic [31:0]       imm_s;
  logic [31:0]       imm_b;
  logic [31:0]       imm_j;
  logic [31:0]       imm_u;
  logic [31:0]       shamt;
  logic              accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_instruction_word;
      addr_r <= in_instruction_address;
    end
  end

  assign f3 = word_r[14:12];
  assign f7 = word_r[31:25];

  assign imm_i = {{20{word_r[31]}}, word_r[31:20]};
  assign imm_s = {{20{word_r[31]}}, word_r[31:25], word_r[11:7]};
  assign imm_b = {{19{word_r[31]}}, word_r[31], word_r[7], word_r[30:25],
                  word_r[11:8], 1'b0};
  assign imm_j = {{11{word_r[31]}}, word_r[31], word_r[19:12], word_r[20],
                  word_r[30:21], 1'b0};
  assign imm_u = {word_r[31:12], 12'h000};
  assign shamt = {27'd0, word_r[24:20]};

  always_comb begin
    code_nxt = rvd_pkg::MN_ILLEGAL;
    use_rd   = 1'b0;
    use_rs1  = 1'b0;
    use_rs2  = 1'b0;
    use_tgt  = 1'b0;
    use_csr  = 1'b0;
    imm_nxt  = 32'd0;
    if (word_r == rvd_pkg::WORD_ECALL) begin
      code_nxt = rvd_pkg::MN_ECALL;
    end else if (word_r == rvd_pkg::WORD_EBREAK) begin
      code_nxt = rvd_pkg::MN_EBREAK;
    end else begin
      case (word_r[6:0])
        rvd_pkg::OP_LUI: begin
          code_nxt = rvd_pkg::MN_LUI;
          use_rd   = 1'b1;
          imm_nxt  = imm_u;
        end
        rvd_pkg::OP_AUIPC: begin
          code_nxt = rvd_pkg::MN_AUIPC;
          use_rd   = 1'b1;
          imm_nxt  = imm_u;
        end
        rvd_pkg::OP_JAL: begin
          code_nxt = rvd_pkg::MN_JAL;
          use_rd   = 1'b1;
          use_tgt  = 1'b1;
          imm_nxt  = imm_j;
        end
        rvd_pkg::OP_JALR: begin
          code_nxt = rvd_pkg::MN_JALR;
          use_rd   = 1'b1;
          use_rs1  = 1'b1;
          imm_nxt  = imm_i;
        end
        rvd_pkg::OP_BRANCH: begin
          code_nxt = rvd_pkg::BR_CODE[f3];
          if (code_nxt != rvd_pkg::MN_ILLEGAL) begin
            use_rs1 = 1'b1;
            use_rs2 = 1'b1;
            use_tgt = 1'b1;
            imm_nxt = imm_b;
          end
        end
        rvd_pkg::OP_LOAD: begin
          code_nxt = rvd_pkg::LD_CODE[f3];
          if (code_nxt != rvd_pkg::MN_ILLEGAL) begin
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            imm_nxt = imm_i;
          end
        end
        rvd_pkg::OP_STORE: begin
          code_nxt = rvd_pkg::ST_CODE[f3];
          if (code_nxt != rvd_pkg::MN_ILLEGAL) begin
            use_rs1 = 1'b1;
            use_rs2 = 1'b1;
            imm_nxt = imm_s;
          end
        end
        rvd_pkg::OP_ALUI: begin
          code_nxt = rvd_pkg::AI_CODE[f3];
          if (f3 == rvd_pkg::F3_SRL_SRA) begin
            code_nxt = (f7 == rvd_pkg::F7_BASE) ? rvd_pkg::MN_SRLI :
                       (f7 == rvd_pkg::F7_ALT)  ? rvd_pkg::MN_SRAI :
                                                  rvd_pkg::MN_ILLEGAL;
          end
          if (code_nxt != rvd_pkg::MN_ILLEGAL) begin
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            imm_nxt = (f3 == rvd_pkg::F3_SLL || f3 == rvd_pkg::F3_SRL_SRA) ? shamt : imm_i;
          end
        end
        rvd_pkg::OP_ALUR: begin
          code_nxt = rvd_pkg::AR_CODE[f3];
          if (f3 == rvd_pkg::F3_ADD_SUB) begin
            code_nxt = (f7 == rvd_pkg::F7_BASE) ? rvd_pkg::MN_ADD :
                       (f7 == rvd_pkg::F7_ALT)  ? rvd_pkg::MN_SUB :
                                                  rvd_pkg::MN_ILLEGAL;
          end
          if (f3 == rvd_pkg::F3_SRL_SRA) begin
            code_nxt = (f7 == rvd_pkg::F7_BASE) ? rvd_pkg::MN_SRL :
                       (f7 == rvd_pkg::F7_ALT)  ? rvd_pkg::MN_SRA :
                                                  rvd_pkg::MN_ILLEGAL;
          end
          if (code_nxt != rvd_pkg::MN_ILLEGAL) begin
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            use_rs2 = 1'b1;
          end
        end
        rvd_pkg::OP_SYSTEM: begin
          code_nxt = rvd_pkg::CS_CODE[f3];
          if (code_nxt != rvd_pkg::MN_ILLEGAL) begin
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            use_csr = 1'b1;
          end
        end
        default: begin
          code_nxt = rvd_pkg::MN_ILLEGAL;
        end
      endcase
    end
  end

  assign rd_nxt  = use_rd  ? word_r[11:7]  : 5'd0;
  assign rs1_nxt = use_rs1 ? word_r[19:15] : 5'd0;
  assign rs2_nxt = use_rs2 ? word_r[24:20] : 5'd0;
  assign tgt_nxt = use_tgt ? addr_r + imm_nxt : 32'd0;
  assign csr_nxt = use_csr ? word_r[31:20] : 12'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      code_r    <= code_nxt;
      illegal_r <= (code_nxt == rvd_pkg::MN_ILLEGAL);
      rd_r      <= rd_nxt;
      rs1_r     <= rs1_nxt;
      rs2_r     <= rs2_nxt;
      imm_r     <= imm_nxt;
      tgt_r     <= tgt_nxt;
      csr_r     <= csr_nxt;
    end
  end

  assign out_valid           = res_vld_r;
  assign out_mnemonic_code   = code_r;
  assign out_illegal_flag    = illegal_r;
  assign out_dest_reg        = rd_r;
  assign out_src1_reg        = rs1_r;
  assign out_src2_reg        = rs2_r;
  assign out_immediate_value = $signed(imm_r);
  assign out_target_address  = tgt_r;
  assign out_csr_number      = csr_r;

endmodule

// ----- rtl/rvd_checker.sv -----
// Port-level checker for the RV32I instruction decoder, with its bind.
// Sees only the top level's ports; uses rvd_pkg for the mnemonic codes.
module rvd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [5:0]        out_mnemonic_code,
  input logic              out_illegal_flag,
  input logic [4:0]        out_dest_reg,
  input logic [4:0]        out_src1_reg,
  input logic [4:0]        out_src2_reg,
  input logic signed [31:0] out_immediate_value,
  input logic [31:0]       out_target_address,
  input logic [11:0]       out_csr_number
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("request not answered two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  a_illegal_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_illegal_flag == (out_mnemonic_code == rvd_pkg::MN_ILLEGAL)))
    else $error("illegal flag disagrees with mnemonic code");

  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_illegal_flag) |-> (out_dest_reg == 5'd0 && out_src1_reg == 5'd0 &&
      out_src2_reg == 5'd0 && out_immediate_value == 32'sd0 &&
      out_target_address == 32'd0 && out_csr_number == 12'd0))
    else $error("illegal result carries non-zero fields");

  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mnemonic_code != rvd_pkg::MN_JAL &&
     (out_mnemonic_code < rvd_pkg::MN_BEQ || out_mnemonic_code > rvd_pkg::MN_BGEU))
    |-> (out_target_address == 32'd0))
    else $error("target set for an instruction without one");

endmodule

bind rv32i_instruction_decoder rvd_checker u_rvd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_mnemonic_code   (out_mnemonic_code),
  .out_illegal_flag    (out_illegal_flag),
  .out_dest_reg        (out_dest_reg),
  .out_src1_reg        (out_src1_reg),
  .out_src2_reg        (out_src2_reg),
  .out_immediate_value (out_immediate_value),
  .out_target_address  (out_target_address),
  .out_csr_number      (out_csr_number)
);

// ----- dv/rv32i_instruction_decoder_test.sv -----
// Self-checking testbench for the RV32I instruction decoder: directed and random
// instruction words, each decode predicted independently and compared with the result.
// Depends on rvd_pkg and rv32i_instruction_decoder.
module rv32i_instruction_decoder_test;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PER_PHASE = 370;
  localparam int unsigned MAX_REPORTS = 10;

  localparam rvd_pkg::funct3_t F3_WORD   = 3'd2;
  localparam rvd_pkg::funct3_t F3_HOLE   = 3'd3;
  localparam rvd_pkg::funct3_t F3_BYTE_U = 3'd4;
  localparam rvd_pkg::funct3_t F3_TOP    = 3'd7;

  localparam rvd_pkg::mnem_t BRANCH_OPS [8] = '{
    rvd_pkg::MN_BEQ, rvd_pkg::MN_BNE, rvd_pkg::MN_ILLEGAL, rvd_pkg::MN_ILLEGAL,
    rvd_pkg::MN_BLT, rvd_pkg::MN_BGE, rvd_pkg::MN_BLTU, rvd_pkg::MN_BGEU};
  localparam rvd_pkg::mnem_t LOAD_OPS [8] = '{
    rvd_pkg::MN_LB, rvd_pkg::MN_LH, rvd_pkg::MN_LW, rvd_pkg::MN_ILLEGAL,
    rvd_pkg::MN_LBU, rvd_pkg::MN_LHU, rvd_pkg::MN_ILLEGAL, rvd_pkg::MN_ILLEGAL};
  localparam rvd_pkg::mnem_t STORE_OPS [8] = '{
    rvd_pkg::MN_SB, rvd_pkg::MN_SH, rvd_pkg::MN_SW, rvd_pkg::MN_ILLEGAL,
    rvd_pkg::MN_ILLEGAL, rvd_pkg::MN_ILLEGAL, rvd_pkg::MN_ILLEGAL, rvd_pkg::MN_ILLEGAL};
  localparam rvd_pkg::mnem_t ALU_IMM_OPS [8] = '{
    rvd_pkg::MN_ADDI, rvd_pkg::MN_SLLI, rvd_pkg::MN_SLTI, rvd_pkg::MN_SLTIU,
    rvd_pkg::MN_XORI, rvd_pkg::MN_ILLEGAL, rvd_pkg::MN_ORI, rvd_pkg::MN_ANDI};
  localparam rvd_pkg::mnem_t ALU_REG_OPS [8] = '{
    rvd_pkg::MN_ADD, rvd_pkg::MN_SLL, rvd_pkg::MN_SLT, rvd_pkg::MN_SLTU,
    rvd_pkg::MN_XOR, rvd_pkg::MN_SRL, rvd_pkg::MN_OR, rvd_pkg::MN_AND};
  localparam rvd_pkg::mnem_t SYSTEM_OPS [8] = '{
    rvd_pkg::MN_ILLEGAL, rvd_pkg::MN_CSRRW, rvd_pkg::MN_CSRRS, rvd_pkg::MN_CSRRC,
    rvd_pkg::MN_ILLEGAL, rvd_pkg::MN_CSRRWI, rvd_pkg::MN_CSRRSI, rvd_pkg::MN_CSRRCI};
  localparam rvd_pkg::opcode_t OPCODES [10] = '{
    rvd_pkg::OP_LUI, rvd_pkg::OP_AUIPC, rvd_pkg::OP_JAL, rvd_pkg::OP_JALR,
    rvd_pkg::OP_BRANCH, rvd_pkg::OP_LOAD, rvd_pkg::OP_STORE, rvd_pkg::OP_ALUI,
    rvd_pkg::OP_ALUR, rvd_pkg::OP_SYSTEM};
  localparam int unsigned GAP_PHASES [4] = '{0, 80, 0, 21};

  typedef struct packed {
    rvd_pkg::mnem_t code;
    logic           illegal;
    logic [4:0]     rd;
    logic [4:0]     rs1;
    logic [4:0]     rs2;
    logic [31:0]    imm;
    logic [31:0]    target;
    logic [11:0]    csr;
  } decoded_t;

  typedef struct {
    logic [31:0] word;
    logic [31:0] addr;
    int unsigned gap_pct;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_instruction_word = '0;
  logic [31:0] in_instruction_address = '0;
  logic out_valid;
  logic [5:0] out_mnemonic_code;
  logic out_illegal_flag;
  logic [4:0] out_dest_reg;
  logic [4:0] out_src1_reg;
  logic [4:0] out_src2_reg;
  logic signed [31:0] out_immediate_value;
  logic [31:0] out_target_address;
  logic [11:0] out_csr_number;

  request_t pending_q[$];
  decoded_t expected_q[$];
  logic [31:0] word_q[$];
  request_t next_req;
  decoded_t got;
  decoded_t want;
  logic [31:0] want_word;
  logic req_taken = 1'b0;
  logic [63:0] seen_codes = '0;
  int unsigned quiet_cycles = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_illegal = 0;
  int unsigned n_errors = 0;

  rv32i_instruction_decoder i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_instruction_word    (in_instruction_word),
    .in_instruction_address (in_instruction_address),
    .out_valid              (out_valid),
    .out_mnemonic_code      (out_mnemonic_code),
    .out_illegal_flag       (out_illegal_flag),
    .out_dest_reg           (out_dest_reg),
    .out_src1_reg           (out_src1_reg),
    .out_src2_reg           (out_src2_reg),
    .out_immediate_value    (out_immediate_value),
    .out_target_address     (out_target_address),
    .out_csr_number         (out_csr_number)
  );

  always #5 clk = ~clk;

  function automatic decoded_t decode_word(logic [31:0] w, logic [31:0] pc);
    decoded_t d;
    rvd_pkg::funct3_t f3;
    rvd_pkg::funct7_t f7;
    logic has_rd, has_rs1, has_rs2;
    logic [31:0] imm_i, imm_s, imm_b, imm_j;
    d = '0;
    has_rd = 1'b0;
    has_rs1 = 1'b0;
    has_rs2 = 1'b0;
    f3 = w[14:12];
    f7 = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    if (w == rvd_pkg::WORD_ECALL) begin
      d.code = rvd_pkg::MN_ECALL;
    end else if (w == rvd_pkg::WORD_EBREAK) begin
      d.code = rvd_pkg::MN_EBREAK;
    end else begin
      case (w[6:0])
        rvd_pkg::OP_LUI, rvd_pkg::OP_AUIPC: begin
          d.code = (w[6:0] == rvd_pkg::OP_LUI) ? rvd_pkg::MN_LUI : rvd_pkg::MN_AUIPC;
          has_rd = 1'b1;
          d.imm = {w[31:12], 12'b0};
        end
        rvd_pkg::OP_JAL: begin
          d.code = rvd_pkg::MN_JAL;
          has_rd = 1'b1;
          d.imm = imm_j;
          d.target = pc + imm_j;
        end
        rvd_pkg::OP_JALR: begin
          d.code = rvd_pkg::MN_JALR;
          has_rd = 1'b1;
          has_rs1 = 1'b1;
          d.imm = imm_i;
        end
        rvd_pkg::OP_BRANCH: begin
          d.code = BRANCH_OPS[f3];
          if (d.code != rvd_pkg::MN_ILLEGAL) begin
            has_rs1 = 1'b1;
            has_rs2 = 1'b1;
            d.imm = imm_b;
            d.target = pc + imm_b;
          end
        end
        rvd_pkg::OP_LOAD: begin
          d.code = LOAD_OPS[f3];
          if (d.code != rvd_pkg::MN_ILLEGAL) begin
            has_rd = 1'b1;
            has_rs1 = 1'b1;
            d.imm = imm_i;
          end
        end
        rvd_pkg::OP_STORE: begin
          d.code = STORE_OPS[f3];
          if (d.code != rvd_pkg::MN_ILLEGAL) begin
            has_rs1 = 1'b1;
            has_rs2 = 1'b1;
            d.imm = imm_s;
          end
        end
        rvd_pkg::OP_ALUI: begin
          d.code = ALU_IMM_OPS[f3];
          if (f3 == rvd_pkg::F3_SRL_SRA)
            d.code = (f7 == rvd_pkg::F7_BASE) ? rvd_pkg::MN_SRLI :
                     (f7 == rvd_pkg::F7_ALT)  ? rvd_pkg::MN_SRAI : rvd_pkg::MN_ILLEGAL;
          if (d.code != rvd_pkg::MN_ILLEGAL) begin
            has_rd = 1'b1;
            has_rs1 = 1'b1;
            d.imm = (f3 == rvd_pkg::F3_SLL || f3 == rvd_pkg::F3_SRL_SRA) ?
                    {27'b0, w[24:20]} : imm_i;
          end
        end
        rvd_pkg::OP_ALUR: begin
          d.code = ALU_REG_OPS[f3];
          if (f3 == rvd_pkg::F3_ADD_SUB)
            d.code = (f7 == rvd_pkg::F7_BASE) ? rvd_pkg::MN_ADD :
                     (f7 == rvd_pkg::F7_ALT)  ? rvd_pkg::MN_SUB : rvd_pkg::MN_ILLEGAL;
          if (f3 == rvd_pkg::F3_SRL_SRA)
            d.code = (f7 == rvd_pkg::F7_BASE) ? rvd_pkg::MN_SRL :
                     (f7 == rvd_pkg::F7_ALT)  ? rvd_pkg::MN_SRA : rvd_pkg::MN_ILLEGAL;
          if (d.code != rvd_pkg::MN_ILLEGAL) begin
            has_rd = 1'b1;
            has_rs1 = 1'b1;
            has_rs2 = 1'b1;
          end
        end
        rvd_pkg::OP_SYSTEM: begin
          d.code = SYSTEM_OPS[f3];
          if (d.code != rvd_pkg::MN_ILLEGAL) begin
            has_rd = 1'b1;
            has_rs1 = 1'b1;
            d.csr = w[31:20];
          end
        end
        default: d.code = rvd_pkg::MN_ILLEGAL;
      endcase
    end
    d.illegal = (d.code == rvd_pkg::MN_ILLEGAL);
    if (has_rd) d.rd = w[11:7];
    if (has_rs1) d.rs1 = w[19:15];
    if (has_rs2) d.rs2 = w[24:20];
    return d;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned roll;
    w = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      w[6:0] = OPCODES[4'($urandom_range(0, 9))];
      if ((w[6:0] == rvd_pkg::OP_ALUR &&
           (w[14:12] == rvd_pkg::F3_ADD_SUB || w[14:12] == rvd_pkg::F3_SRL_SRA)) ||
          (w[6:0] == rvd_pkg::OP_ALUI && w[14:12] == rvd_pkg::F3_SRL_SRA)) begin
        if ($urandom_range(0, 3) != 0)
          w[31:25] = $urandom_range(0, 1) ? rvd_pkg::F7_ALT : rvd_pkg::F7_BASE;
      end else if (w[6:0] == rvd_pkg::OP_SYSTEM && $urandom_range(0, 9) == 0) begin
        w = $urandom_range(0, 1) ? rvd_pkg::WORD_ECALL : rvd_pkg::WORD_EBREAK;
      end
    end else if (roll < 90) begin
      w[1:0] = 2'b11;
    end
    return w;
  endfunction

  function automatic logic [31:0] random_address();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'hffff_fff0 | 32'($urandom_range(0, 15));
      2: return 32'h7fff_fff0 | 32'($urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic string show(decoded_t d);
    return $sformatf("code=%0d ill=%0b rd=%0d rs1=%0d rs2=%0d imm=%h tgt=%h csr=%h",
                     d.code, d.illegal, d.rd, d.rs1, d.rs2, d.imm, d.target, d.csr);
  endfunction

  task automatic queue_request(logic [31:0] word, logic [31:0] addr, int unsigned gap_pct);
    request_t r;
    r.word = word;
    r.addr = addr;
    r.gap_pct = gap_pct;
    pending_q.push_back(r);
  endtask

  task automatic flag_error(string what, logic [31:0] word, decoded_t exp_d, decoded_t got_d);
    if (n_errors < MAX_REPORTS) begin
      $display("%s, word %h at %0t", what, word, $time);
      $display("  expected %s", show(exp_d));
      $display("  actual   %s", show(got_d));
    end
    n_errors++;
  endtask

  // hold a request until taken, then advance or idle
  always @(negedge clk) begin
    if (rst_n && !(start && !req_taken)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= pending_q[0].gap_pct) begin
        next_req = pending_q.pop_front();
        start <= 1'b1;
        in_instruction_word <= next_req.word;
        in_instruction_address <= next_req.addr;
      end else begin
        start <= 1'b0;
        in_instruction_word <= $urandom;
        in_instruction_address <= $urandom;
      end
    end
  end

  always @(posedge clk) begin
    req_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      want = decode_word(in_instruction_word, in_instruction_address);
      expected_q.push_back(want);
      word_q.push_back(in_instruction_word);
      seen_codes[want.code] = 1'b1;
      if (want.illegal) n_illegal++;
      n_requests++;
    end
    if (rst_n && out_valid) begin
      got = {out_mnemonic_code, out_illegal_flag, out_dest_reg, out_src1_reg, out_src2_reg,
             out_immediate_value, out_target_address, out_csr_number};
      n_results++;
      if (expected_q.size() == 0) begin
        flag_error("result with no request outstanding", '0, '0, got);
      end else begin
        want = expected_q.pop_front();
        want_word = word_q.pop_front();
        if (got !== want) flag_error("decode mismatch", want_word, want, got);
      end
    end
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    queue_request(32'h0000_0000, 32'h0000_0000, 0);
    queue_request(32'hffff_ffff, 32'hffff_ffff, 0);
    queue_request(rvd_pkg::WORD_ECALL, 32'h0000_1000, 0);
    queue_request(rvd_pkg::WORD_EBREAK, 32'h0000_1004, 0);
    queue_request(rvd_pkg::WORD_ECALL | 32'h0000_0080, 32'h0000_1008, 0);
    queue_request(rvd_pkg::WORD_EBREAK | 32'h0000_8000, 32'h0000_100c, 0);
    queue_request({12'h000, 5'd0, F3_BYTE_U, 5'd0, rvd_pkg::OP_SYSTEM}, 32'h0000_1010, 0);
    queue_request({20'hfffff, 5'd31, rvd_pkg::OP_LUI}, 32'h0000_0000, 0);
    queue_request({20'h80000, 5'd1, rvd_pkg::OP_AUIPC}, 32'hffff_ffff, 0);
    queue_request({1'b1, 10'h000, 1'b0, 8'h00, 5'd0, rvd_pkg::OP_JAL}, 32'h0000_0000, 0);
    queue_request({1'b0, 10'h3ff, 1'b1, 8'hff, 5'd31, rvd_pkg::OP_JAL}, 32'hffff_fff0, 0);
    queue_request({12'hfff, 5'd31, F3_TOP, 5'd31, rvd_pkg::OP_JALR}, 32'h8000_0000, 0);
    queue_request({7'h7f, 5'd31, 5'd31, F3_TOP, 5'd31, rvd_pkg::OP_BRANCH},
                  32'h0000_0000, 0);
    queue_request({7'h00, 5'd0, 5'd0, rvd_pkg::F3_ADD_SUB, 5'd0, rvd_pkg::OP_BRANCH},
                  32'hffff_fffc, 0);
    queue_request({7'h55, 5'd10, 5'd11, F3_WORD, 5'd12, rvd_pkg::OP_BRANCH},
                  32'h0000_2000, 0);
    queue_request({12'h800, 5'd1, F3_HOLE, 5'd2, rvd_pkg::OP_LOAD}, 32'h0000_2004, 0);
    queue_request({7'h7f, 5'd31, 5'd31, F3_WORD, 5'd31, rvd_pkg::OP_STORE},
                  32'h0000_2008, 0);
    queue_request({7'h12, 5'd3, 5'd4, F3_BYTE_U, 5'd5, rvd_pkg::OP_STORE},
                  32'h0000_200c, 0);
    queue_request({7'h7f, 5'd31, 5'd31, rvd_pkg::F3_SLL, 5'd31, rvd_pkg::OP_ALUI},
                  32'h0000_2010, 0);
    queue_request({rvd_pkg::F7_ALT, 5'd31, 5'd1, rvd_pkg::F3_SRL_SRA, 5'd2, rvd_pkg::OP_ALUI},
                  32'h0000_2014, 0);
    queue_request({7'h01, 5'd7, 5'd1, rvd_pkg::F3_SRL_SRA, 5'd2, rvd_pkg::OP_ALUI},
                  32'h0000_2018, 0);
    queue_request({12'h800, 5'd0, rvd_pkg::F3_ADD_SUB, 5'd0, rvd_pkg::OP_ALUI},
                  32'h0000_201c, 0);
    queue_request({rvd_pkg::F7_ALT, 5'd3, 5'd4, rvd_pkg::F3_ADD_SUB, 5'd5, rvd_pkg::OP_ALUR},
                  32'h0000_2020, 0);
    queue_request({7'h7f, 5'd3, 5'd4, rvd_pkg::F3_ADD_SUB, 5'd5, rvd_pkg::OP_ALUR},
                  32'h0000_2024, 0);
    queue_request({rvd_pkg::F7_ALT, 5'd6, 5'd7, rvd_pkg::F3_SRL_SRA, 5'd8, rvd_pkg::OP_ALUR},
                  32'h0000_2028, 0);
    queue_request({7'h7f, 5'd31, 5'd31, F3_TOP, 5'd31, rvd_pkg::OP_ALUR}, 32'h0000_202c, 0);
    queue_request({12'hfff, 5'd31, F3_TOP, 5'd31, rvd_pkg::OP_SYSTEM}, 32'h0000_2030, 0);
    foreach (GAP_PHASES[p])
      repeat (RANDOM_PER_PHASE) queue_request(random_word(), random_address(), GAP_PHASES[p]);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("decoded %0d instruction words (%0d illegal), %0d results checked",
             n_requests, n_illegal, n_results);
    $display("%0d of 46 mnemonic codes exercised, %0d errors", $countones(seen_codes), n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
